/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the running Gaussian background block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication into the next cycle, ignored while reset is asserted.
`define RGB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Property checked in the cycle after any reset cycle.
`define RGB_ASSERT_AFTER_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) else $error(msg);

`endif

/* rtl/core/rgb_pkg.sv */
// ----------------------------------------------------------------------------
// rgb_pkg
// Types, constants and helper functions of the running Gaussian background unit.
// ----------------------------------------------------------------------------
package rgb_pkg;

    localparam int unsigned IDX_W          = 19;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned UNIT_W         = 16;
    localparam int unsigned ALPHA_W        = 16;
    localparam int unsigned CH             = 3;
    localparam int unsigned DIV_W          = 32;
    localparam int unsigned SUM_W          = 34;
    localparam int unsigned TDATA_W        = 48;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam int unsigned UPD_STAGES     = 5;
    localparam int unsigned PIXELS_DEFAULT = 524288;

    localparam logic [UNIT_W-1:0]     VAR_INIT     = 16'd39322;
    localparam logic [ALPHA_W-1:0]    ALPHA_RESET  = 16'd655;
    localparam logic [CFG_DATA_W-1:0] THRESH_RESET = 32'd589824;

    typedef enum logic {
        FUNC_LOAD    = 1'b0,
        FUNC_PROCESS = 1'b1
    } func_t;

    typedef enum logic {
        CFG_ALPHA        = 1'b0,
        CFG_THRESHOLD_SQ = 1'b1
    } cfg_reg_t;

    typedef logic [CH-1:0][UNIT_W-1:0] unit3_t;
    typedef logic [CH-1:0][BYTE_W-1:0] byte3_t;
    typedef logic [CH-1:0][DIV_W-1:0]  word3_t;

    typedef struct packed {
        func_t            func;
        logic [IDX_W-1:0] idx;
        byte3_t           px;
    } item_t;

    typedef struct packed {
        logic   valid;
        item_t  item;
        word3_t num;
        unit3_t den;
        unit3_t mean;
    } upd_out_t;

    // byte/255 as Q0.16 rounded as the model does: b*257 plus one for the upper half.
    function automatic logic [UNIT_W-1:0] to_unit(input logic [BYTE_W-1:0] b);
        logic [UNIT_W:0] x;
        x = {1'b0, b, b} + 17'(b[BYTE_W-1]);
        return x[UNIT_W] ? {UNIT_W{1'b1}} : x[UNIT_W-1:0];
    endfunction

    // round(m*255 / 65536)
    function automatic logic [BYTE_W-1:0] to_byte(input logic [UNIT_W-1:0] m);
        logic [23:0] p;
        p = {m, 8'd0} - {8'd0, m} + 24'd32768;
        return p[23:16];
    endfunction

    // Number of compare-subtract steps that reduce an index modulo p.
    function automatic int unsigned mod_steps(input int unsigned p);
        int unsigned n;
        n = 0;
        for (int k = 0; k < IDX_W; k++) begin
            if ((64'(p) << k) < (64'd1 << IDX_W)) n++;
        end
        return n;
    endfunction

endpackage

/* rtl/core/rgb_state_ram.sv */
// ----------------------------------------------------------------------------
// rgb_state_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rgb_state_ram #(
    parameter int unsigned DEPTH  = 524288,
    parameter int unsigned ADDR_W = 19,
    parameter int unsigned DATA_W = 48
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/rgb_update.sv */
// ----------------------------------------------------------------------------
// rgb_update
// Five-stage mean and variance update; produces the write-back and the
// operands of the distance division.
// ----------------------------------------------------------------------------
module rgb_update #(
    parameter int unsigned SLOT_W = 19
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        en,
    input  logic [rgb_pkg::ALPHA_W-1:0]                 alpha,
    input  logic                                        in_valid,
    input  rgb_pkg::item_t                              in_item,
    input  logic [SLOT_W-1:0]                           in_slot,
    input  rgb_pkg::unit3_t                             rd_mean,
    input  rgb_pkg::unit3_t                             rd_var,
    output logic [rgb_pkg::UPD_STAGES-1:0]              busy_valid,
    output logic [rgb_pkg::UPD_STAGES-1:0][SLOT_W-1:0]  busy_slot,
    output logic                                        wr_en,
    output logic [SLOT_W-1:0]                           wr_addr,
    output rgb_pkg::unit3_t                             wr_mean,
    output rgb_pkg::unit3_t                             wr_var,
    output rgb_pkg::upd_out_t                           upd_out
);
    import rgb_pkg::*;

    localparam int unsigned LAST = UPD_STAGES - 1;

    logic [UPD_STAGES-1:0] valid_reg;
    item_t                 item_reg [UPD_STAGES];
    logic [SLOT_W-1:0]     slot_reg [UPD_STAGES];

    // stage 2
    unit3_t src2_reg, mean2_reg, vv2_reg, mag2_reg;
    logic [CH-1:0] neg2_reg;
    // stage 3
    unit3_t src3_reg, mean3_reg, vv3_reg;
    logic [CH-1:0] neg3_reg;
    word3_t d2_3_reg, ma3_reg;
    // stage 4
    unit3_t src4_reg, nm4_reg, vv4_reg;
    word3_t d2_4_reg;
    logic [CH-1:0][47:0] d2a4_reg;
    // stage 5
    unit3_t src5_reg, nm5_reg, vv5_reg;
    word3_t d2_5_reg;
    logic [CH-1:0][UNIT_W:0] s5_reg;

    unit3_t src1_next, mag1_next, vv1_next;
    logic [CH-1:0] neg1_next;
    word3_t d2_next, ma_next;
    unit3_t nm_next;
    logic [CH-1:0][47:0] d2a_next;
    logic [CH-1:0][UNIT_W:0] s_next;
    unit3_t nv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[UPD_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= in_item;
            slot_reg[0] <= in_slot;
            for (int i = 1; i < UPD_STAGES; i++) begin
                item_reg[i] <= item_reg[i-1];
                slot_reg[i] <= slot_reg[i-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < UPD_STAGES; i++) begin
            busy_slot[i] = slot_reg[i];
        end
        busy_valid = valid_reg;
    end

    // Stage 1: difference magnitude against the stored mean.
    always_comb begin
        for (int c = 0; c < CH; c++) begin
            src1_next[c] = to_unit(item_reg[0].px[c]);
            neg1_next[c] = src1_next[c] < rd_mean[c];
            mag1_next[c] = neg1_next[c] ? rd_mean[c] - src1_next[c]
                                        : src1_next[c] - rd_mean[c];
            vv1_next[c]  = (rd_var[c] == '0) ? UNIT_W'(1) : rd_var[c];
        end
    end

    // Stage 2: squared difference and alpha times difference.
    always_comb begin
        for (int c = 0; c < CH; c++) begin
            d2_next[c] = {16'd0, mag2_reg[c]} * {16'd0, mag2_reg[c]};
            ma_next[c] = {16'd0, mag2_reg[c]} * {16'd0, alpha};
        end
    end

    // Stage 3: new mean, alpha times squared difference.
    always_comb begin
        logic [UNIT_W-1:0] r;
        logic [UNIT_W:0]   up;
        for (int c = 0; c < CH; c++) begin
            r  = ma3_reg[c][31:16] + 16'(ma3_reg[c][15]);
            up = {1'b0, mean3_reg[c]} + {1'b0, r};
            if (neg3_reg[c]) begin
                nm_next[c] = (mean3_reg[c] < r) ? '0 : mean3_reg[c] - r;
            end else begin
                nm_next[c] = up[UNIT_W] ? {UNIT_W{1'b1}} : up[UNIT_W-1:0];
            end
            d2a_next[c] = {16'd0, d2_3_reg[c]} * {32'd0, alpha};
        end
    end

    // Stage 4: variance plus rounded alpha*d^2.
    always_comb begin
        logic [47:0] t;
        for (int c = 0; c < CH; c++) begin
            t         = d2a4_reg[c] + 48'h0000_8000_0000;
            s_next[c] = {1'b0, vv4_reg[c]} + {1'b0, t[47:32]};
        end
    end

    // Stage 5: scale by (1 - alpha), round, clamp.
    always_comb begin
        logic [UNIT_W:0]   om;
        logic [33:0]       prod;
        logic [33:0]       rnd;
        om = 17'h10000 - {1'b0, alpha};
        for (int c = 0; c < CH; c++) begin
            prod = {17'd0, s5_reg[c]} * {17'd0, om};
            rnd  = prod + 34'd32768;
            if (rnd[33:16] == '0) begin
                nv_next[c] = UNIT_W'(1);
            end else if (rnd[33:32] != '0) begin
                nv_next[c] = {UNIT_W{1'b1}};
            end else begin
                nv_next[c] = rnd[31:16];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            src2_reg  <= src1_next;
            mean2_reg <= rd_mean;
            vv2_reg   <= vv1_next;
            mag2_reg  <= mag1_next;
            neg2_reg  <= neg1_next;

            src3_reg  <= src2_reg;
            mean3_reg <= mean2_reg;
            vv3_reg   <= vv2_reg;
            neg3_reg  <= neg2_reg;
            d2_3_reg  <= d2_next;
            ma3_reg   <= ma_next;

            src4_reg  <= src3_reg;
            nm4_reg   <= nm_next;
            vv4_reg   <= vv3_reg;
            d2_4_reg  <= d2_3_reg;
            d2a4_reg  <= d2a_next;

            src5_reg  <= src4_reg;
            nm5_reg   <= nm4_reg;
            vv5_reg   <= vv4_reg;
            d2_5_reg  <= d2_4_reg;
            s5_reg    <= s_next;
        end
    end

    always_comb begin
        if (item_reg[LAST].func == FUNC_LOAD) begin
            wr_mean = src5_reg;
            wr_var  = {CH{VAR_INIT}};
        end else begin
            wr_mean = nm5_reg;
            wr_var  = nv_next;
        end
        wr_en   = en && valid_reg[LAST];
        wr_addr = slot_reg[LAST];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_out.valid <= 1'b0;
        end else if (en) begin
            upd_out.valid <= valid_reg[LAST];
        end
        if (en) begin
            upd_out.item <= item_reg[LAST];
            upd_out.num  <= d2_5_reg;
            upd_out.den  <= vv5_reg;
            upd_out.mean <= wr_mean;
        end
    end

endmodule

/* rtl/core/rgb_div.sv */
// ----------------------------------------------------------------------------
// rgb_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rgb_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  rgb_pkg::item_t  in_tag,
    input  rgb_pkg::word3_t in_num,
    input  rgb_pkg::unit3_t in_den,
    output logic            out_valid,
    output rgb_pkg::item_t  out_tag,
    output rgb_pkg::word3_t out_quo
);
    import rgb_pkg::*;

    typedef struct packed {
        item_t  tag;
        unit3_t rem;
        word3_t num;
        word3_t quo;
        unit3_t den;
    } dstage_t;

    function automatic dstage_t div_step(input dstage_t s);
        dstage_t         r;
        logic [UNIT_W:0] t;
        r = s;
        for (int c = 0; c < CH; c++) begin
            t = {s.rem[c], s.num[c][DIV_W-1]};
            if (t >= {1'b0, s.den[c]}) begin
                r.rem[c] = UNIT_W'(t - {1'b0, s.den[c]});
                r.quo[c] = {s.quo[c][DIV_W-2:0], 1'b1};
            end else begin
                r.rem[c] = t[UNIT_W-1:0];
                r.quo[c] = {s.quo[c][DIV_W-2:0], 1'b0};
            end
            r.num[c] = {s.num[c][DIV_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic [DIV_W-1:0] vld_reg;
    dstage_t          st_reg [DIV_W];
    dstage_t          st_in  [DIV_W];

    always_comb begin
        st_in[0].tag = in_tag;
        st_in[0].rem = '0;
        st_in[0].num = in_num;
        st_in[0].quo = '0;
        st_in[0].den = in_den;
        for (int i = 1; i < DIV_W; i++) begin
            st_in[i] = st_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < DIV_W; i++) begin
                st_reg[i] <= div_step(st_in[i]);
            end
        end
    end

    assign out_valid = vld_reg[DIV_W-1];
    assign out_tag   = st_reg[DIV_W-1].tag;
    assign out_quo   = st_reg[DIV_W-1].quo;

endmodule

/* rtl/core/running_gaussian_background_unit.sv */
// ----------------------------------------------------------------------------
// running_gaussian_background_unit
// Per-pixel running Gaussian background model with foreground detection.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake         Payload
//  s_*       in         tvalid / tready   tdata: pixel index, red, green, blue
//                                         tuser: function (load / process)
//  m_*       out        tvalid / tready   tdata: pixel index, bg red/green/blue
//                                         tuser: foreground flag
//  cfg_*     in         write enable      cfg_index selects alpha or threshold
//
//  One item is accepted per clock while s_tready is high; the same-pixel interlock
//  and a full skid register hold it low. A result passes the capture register, a
//  register per index reduction step (none when PIXELS is at least 2^19), the five
//  update stages, the update output register, the 32-stage quotient pipeline (its
//  largest part), the sum register and the output register. An item whose pixel is
//  still in the five-stage read-modify-write loop waits at the memory read stage.
//  Reset is synchronous and active low; the memories are not cleared and a
//  pixel must be loaded before it is processed.
//  When the output is stalled, a skid register takes one more result and the
//  whole pipeline then holds until the output moves.
// ----------------------------------------------------------------------------
module running_gaussian_background_unit #(
    parameter int unsigned PIXELS = rgb_pkg::PIXELS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [rgb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rgb_pkg::TDATA_W-1:0]    s_tdata,  // pixel_index, red, green, blue, pad
    input  logic                           s_tuser,  // func
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rgb_pkg::TDATA_W-1:0]    m_tdata,  // pixel_index_out, bg_red, bg_green,
                                                     // bg_blue, pad
    output logic                           m_tuser   // foreground
);
    import rgb_pkg::*;

    localparam int unsigned SLOT_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int unsigned MOD_N  = mod_steps(PIXELS);
    localparam int unsigned PAD_W  = TDATA_W - IDX_W - CH * BYTE_W;

    typedef struct packed {
        logic             valid;
        item_t            item;
        logic [IDX_W-1:0] rem;
    } front_t;

    // Configuration registers.
    logic [ALPHA_W-1:0]    alpha_reg;
    logic [CFG_DATA_W-1:0] thresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= ALPHA_RESET;
            thresh_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ALPHA:        alpha_reg  <= cfg_wdata[ALPHA_W-1:0];
                CFG_THRESHOLD_SQ: thresh_reg <= cfg_wdata;
            endcase
        end
    end

    // Global advance: all stages move unless the skid is full; a hazard holds the front end.
    logic skid_valid_reg;
    logic en;
    logic hazard;
    logic en_front;

    assign en       = !skid_valid_reg;
    assign en_front = en && !hazard;
    assign s_tready = en_front;

    // Front end: capture, then reduce the index modulo PIXELS one
    // compare-subtract per stage, largest multiple first.
    front_t front_reg [MOD_N+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg[0].valid <= 1'b0;
        end else if (en_front) begin
            front_reg[0].valid     <= s_tvalid;
            front_reg[0].item.func <= func_t'(s_tuser);
            front_reg[0].item.idx  <= s_tdata[IDX_W-1:0];
            front_reg[0].item.px   <= s_tdata[IDX_W +: CH*BYTE_W];
            front_reg[0].rem       <= s_tdata[IDX_W-1:0];
        end
    end

    for (genvar i = 0; i < MOD_N; i++) begin : g_mod
        localparam logic [IDX_W-1:0] SUB = IDX_W'(64'(PIXELS) << (MOD_N - 1 - i));
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                front_reg[i+1].valid <= 1'b0;
            end else if (en_front) begin
                front_reg[i+1] <= front_reg[i];
                if (front_reg[i].rem >= SUB) begin
                    front_reg[i+1].rem <= front_reg[i].rem - SUB;
                end
            end
        end
    end

    // Read stage: memory address and same-pixel interlock.
    front_t                               rd_stage;
    logic [SLOT_W-1:0]                    rd_slot;
    logic [UPD_STAGES-1:0]                busy_valid;
    logic [UPD_STAGES-1:0][SLOT_W-1:0]    busy_slot;
    logic                                 busy_hit;

    assign rd_stage = front_reg[MOD_N];
    assign rd_slot  = SLOT_W'(rd_stage.rem);

    always_comb begin
        busy_hit = 1'b0;
        for (int i = 0; i < UPD_STAGES; i++) begin
            busy_hit = busy_hit || (busy_valid[i] && (busy_slot[i] == rd_slot));
        end
        hazard = rd_stage.valid && busy_hit;
    end

    // State memories and update pipeline.
    unit3_t            rd_mean, rd_var, wr_mean, wr_var;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    upd_out_t          upd_out;

    rgb_state_ram #(
        .DEPTH  (PIXELS),
        .ADDR_W (SLOT_W),
        .DATA_W (CH * UNIT_W)
    ) u_mean_ram (
        .aclk    (aclk),
        .rd_en   (en),
        .rd_addr (rd_slot),
        .rd_data (rd_mean),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_mean)
    );

    rgb_state_ram #(
        .DEPTH  (PIXELS),
        .ADDR_W (SLOT_W),
        .DATA_W (CH * UNIT_W)
    ) u_var_ram (
        .aclk    (aclk),
        .rd_en   (en),
        .rd_addr (rd_slot),
        .rd_data (rd_var),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_var)
    );

    rgb_update #(
        .SLOT_W (SLOT_W)
    ) u_update (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .alpha      (alpha_reg),
        .in_valid   (rd_stage.valid && !hazard),
        .in_item    (rd_stage.item),
        .in_slot    (rd_slot),
        .rd_mean    (rd_mean),
        .rd_var     (rd_var),
        .busy_valid (busy_valid),
        .busy_slot  (busy_slot),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_mean    (wr_mean),
        .wr_var     (wr_var),
        .upd_out    (upd_out)
    );

    // The background bytes replace the input bytes in the tag that travels
    // with the division.
    item_t div_tag_in;

    always_comb begin
        div_tag_in = upd_out.item;
        for (int c = 0; c < CH; c++) begin
            div_tag_in.px[c] = to_byte(upd_out.mean[c]);
        end
    end

    logic   div_valid;
    item_t  div_tag;
    word3_t div_quo;

    rgb_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (upd_out.valid),
        .in_tag    (div_tag_in),
        .in_num    (upd_out.num),
        .in_den    (upd_out.den),
        .out_valid (div_valid),
        .out_tag   (div_tag),
        .out_quo   (div_quo)
    );

    // Distance sum, then saturation and threshold compare.
    logic             sum_valid_reg;
    item_t            sum_tag_reg;
    logic [SUM_W-1:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (en) begin
            sum_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_tag_reg <= div_tag;
            sum_reg     <= SUM_W'(div_quo[0]) + SUM_W'(div_quo[1]) + SUM_W'(div_quo[2]);
        end
    end

    logic [DIV_W-1:0]   dist_sat;
    logic               pipe_fg;
    logic [TDATA_W-1:0] pipe_data;

    always_comb begin
        dist_sat  = (sum_reg[SUM_W-1:DIV_W] != '0) ? {DIV_W{1'b1}} : sum_reg[DIV_W-1:0];
        pipe_fg   = (sum_tag_reg.func == FUNC_PROCESS) && (dist_sat > thresh_reg);
        pipe_data = {{PAD_W{1'b0}}, sum_tag_reg.px, sum_tag_reg.idx};
    end

    // Output register with one skid entry behind it.
    logic               out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg, skid_data_reg;
    logic               out_fg_reg, skid_fg_reg;
    logic               take;

    assign take = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || take) begin
            out_valid_reg <= sum_valid_reg;
        end else if (sum_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_data_reg <= skid_data_reg;
                out_fg_reg   <= skid_fg_reg;
            end
        end else if (!out_valid_reg || take) begin
            out_data_reg <= pipe_data;
            out_fg_reg   <= pipe_fg;
        end else begin
            skid_data_reg <= pipe_data;
            skid_fg_reg   <= pipe_fg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_fg_reg;

endmodule

/* rtl/core/rgb_checker.sv */
// ----------------------------------------------------------------------------
// rgb_checker
// Port-level assertions for the running Gaussian background unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [rgb_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tuser
);
    import rgb_pkg::*;

    localparam int unsigned USED_W = IDX_W + CH * BYTE_W;

    // A stalled result stays offered.
    `RGB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // Nothing is offered straight after reset.
    `RGB_ASSERT_AFTER_RESET(a_reset_idle, !m_tvalid, "result offered after reset")

    // The padding above the packed fields is always zero.
    `RGB_ASSERT_NEXT(a_pad_zero, m_tvalid, !m_tvalid || (m_tdata[TDATA_W-1:USED_W] == '0), "non-zero tdata padding")

endmodule

bind running_gaussian_background_unit rgb_checker u_rgb_checker (.*);
